>>> hdl/slfp_pkg.sv
`default_nettype none

package slfp_pkg;

    localparam logic [7:0]  SYNC_FIRST    = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND   = 8'h55;
    localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [5:0] {
        HUNT_IDLE    = 6'b000001,
        HUNT_SYNC1   = 6'b000010,
        HUNT_SYNC2   = 6'b000100,
        HUNT_LEN_HI  = 6'b001000,
        HUNT_LEN_LO  = 6'b010000,
        HUNT_PAYLOAD = 6'b100000
    } hunt_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [15:0] frame_length;
        logic [7:0]  frame_check;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

>>> hdl/sync_length_frame_parser.sv
`default_nettype none

// Deframer for sync-word, length-prefixed frames. Each input item is either a
// received byte (op 0) or a millisecond tick (op 1). Bytes walk a hunt for
// 0xAA, 0x55, a big-endian 16-bit length and one check byte; every following
// payload byte comes out as one result item carrying its index, the frame
// length and the check byte (passed through, not verified), with last set on
// the final byte. A zero length or a bad second sync byte drops the hunt back
// to idle. Ticks count idle time (saturating at 65535) and any byte clears it;
// once the count exceeds cfg timeout_limit (reset 2000) the hunt goes idle.
// Rate: one item per clock cycle sustained while out_stall is low. An item
// waits in the input register until it advances into the core, and its
// result is registered in the output buffer as it advances. A two-entry
// output buffer lets the input keep flowing for one more item while
// out_stall is high; after that in_stall rises until results drain.
module sync_length_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       payload_byte,
    output logic [15:0]      byte_index,
    output logic [15:0]      frame_length,
    output logic [7:0]       frame_check,
    output logic             last,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);
    import slfp_pkg::*;

    // input register stage
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_op_reg;
    logic [7:0]  s1_byte_reg;
    logic [15:0] limit_reg;

    logic        advance;
    logic        has_room;
    logic        res_valid;
    result_t     res;
    result_t     out_data;
    logic        accept;

    // the held item moves into the core only when the result buffer can take it
    assign advance  = s1_valid_reg && has_room;
    assign in_stall = s1_valid_reg && !has_room;
    assign accept   = in_valid && !in_stall;

    // configuration is always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            limit_reg    <= TIMEOUT_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op;
            s1_byte_reg <= rx_byte;
        end
    end

    // hunt state machine and result formation
    slfp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .op            (s1_op_reg),
        .rx_byte       (s1_byte_reg),
        .timeout_limit (limit_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    // result register with skid entry
    slfp_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign payload_byte = out_data.payload_byte;
    assign byte_index   = out_data.byte_index;
    assign frame_length = out_data.frame_length;
    assign frame_check  = out_data.frame_check;
    assign last         = out_data.last;

endmodule

`default_nettype wire

>>> hdl/slfp_core.sv
`default_nettype none

module slfp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             op,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [15:0]      timeout_limit,
    output logic                  res_valid,
    output slfp_pkg::result_t     res
);
    import slfp_pkg::*;

    hunt_t       state_reg, state_next;
    logic [15:0] length_reg, length_next;
    logic [7:0]  check_reg, check_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] idle_reg, idle_next;
    logic [16:0] count_inc;
    logic        fin;

    assign count_inc = {1'b0, count_reg} + 17'd1;
    assign fin       = count_inc >= {1'b0, length_reg};

    always_comb
    begin
        state_next  = state_reg;
        length_next = length_reg;
        check_next  = check_reg;
        count_next  = count_reg;
        idle_next   = idle_reg;
        res_valid   = 1'b0;
        res.payload_byte = rx_byte;
        res.byte_index   = count_reg;
        res.frame_length = length_reg;
        res.frame_check  = check_reg;
        res.last         = fin;
        if (step)
        begin
            if (op == OP_TICK)
            begin
                idle_next = (idle_reg == TICKS_MAX) ? idle_reg : idle_reg + 16'd1;
                if (idle_next > timeout_limit)
                begin
                    state_next = HUNT_IDLE;
                end
            end
            else
            begin
                idle_next = '0;
                case (state_reg)
                    HUNT_SYNC1:
                    begin
                        state_next = (rx_byte == SYNC_SECOND) ? HUNT_SYNC2 : HUNT_IDLE;
                    end
                    HUNT_SYNC2:
                    begin
                        length_next = {rx_byte, 8'h00};
                        state_next  = HUNT_LEN_HI;
                    end
                    HUNT_LEN_HI:
                    begin
                        length_next = {length_reg[15:8], rx_byte};
                        state_next  = (length_next != 16'd0) ? HUNT_LEN_LO : HUNT_IDLE;
                    end
                    HUNT_LEN_LO:
                    begin
                        check_next = rx_byte;
                        count_next = '0;
                        state_next = HUNT_PAYLOAD;
                    end
                    HUNT_PAYLOAD:
                    begin
                        res_valid  = 1'b1;
                        count_next = count_inc[15:0];
                        if (fin)
                        begin
                            state_next = HUNT_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next = (rx_byte == SYNC_FIRST) ? HUNT_SYNC1 : HUNT_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= HUNT_IDLE;
            length_reg <= '0;
            check_reg  <= '0;
            count_reg  <= '0;
            idle_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            check_reg  <= check_next;
            count_reg  <= count_next;
            idle_reg   <= idle_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/slfp_outbuf.sv
`default_nettype none

module slfp_outbuf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire slfp_pkg::result_t push_data,
    output logic                   has_room,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output slfp_pkg::result_t      out_data
);
    import slfp_pkg::*;

    // main register drives the port, skid register catches one item under stall
    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign has_room  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_data;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire
